@@ hw/rtl/lcs_pkg.sv @@
// Shared constants, types and fixed-point helpers of the LSTM cell sequence unit.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

   // Layer shape and number format.
   localparam int HIDDEN_SIZE = 10;
   localparam int FRAC_BITS   = 12;

   // Store layout: W, then R, then the input-side bias, then the recurrent bias.
   localparam int R_BASE      = 4 * HIDDEN_SIZE;
   localparam int B_BASE      = R_BASE + 4 * HIDDEN_SIZE * HIDDEN_SIZE;
   localparam int RB_BASE     = B_BASE + 4 * HIDDEN_SIZE;
   localparam int STORE_DEPTH = B_BASE + 8 * HIDDEN_SIZE;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int HW     = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
   localparam int ROW_W  = $clog2(4 * HIDDEN_SIZE);
   localparam int STEP_W = $clog2(HIDDEN_SIZE + 3);
   localparam int ACC_W  = 40;

   // Field widths of the stream ports.
   localparam int WIDX_W = 10;
   localparam int VAL_W  = 16;
   localparam int OIDX_W = 4;

   // Transaction kinds on the request side.
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Gate codes in store order.
   localparam logic [1:0] G_I = 2'd0;
   localparam logic [1:0] G_O = 2'd1;
   localparam logic [1:0] G_F = 2'd2;
   localparam logic [1:0] G_C = 2'd3;

   // Fixed-point constants of the sigmoid approximation.
   localparam int ONE_Q = 1 << FRAC_BITS;
   localparam logic [17:0] SIG_ONE  = 18'(ONE_Q);
   localparam logic [17:0] SIG_T5   = 18'(5 * ONE_Q);
   localparam logic [17:0] SIG_T238 = 18'((19 * ONE_Q) / 8);
   localparam logic [17:0] SIG_C27  = 18'((27 * ONE_Q) / 32);
   localparam logic [17:0] SIG_C5   = 18'((5 * ONE_Q) / 8);
   localparam logic [17:0] SIG_HALF = 18'(ONE_Q / 2);

   // Multiply-accumulate operations issued with each store read.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_MUL_X,
      OP_MUL_H,
      OP_BIAS
   } mac_op_type;

   // Steps of the cell and hidden update and of the result path.
   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_CF,
      UPD_CELL,
      UPD_TANH,
      UPD_HID,
      UPD_OUT,
      UPD_CLEAR
   } upd_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      mac_op_type        op;
      logic              first;
      logic [HW-1:0]     k;
      logic              round;
      logic              act_wr;
      logic [1:0]        gate;
      logic [HW-1:0]     unit;
      upd_op_type        upd;
      logic              out_last;
   } lcs_cmd_type;

   // Round half up to FRAC_BITS and saturate to 16 bits.
   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + ACC_W'(ONE_Q / 2)) >>> FRAC_BITS;
      if (r > ACC_W'(32767)) begin
         return 16'sh7fff;
      end else if (r < -ACC_W'(32768)) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   // Piecewise linear sigmoid on a signed 18-bit argument.
   function automatic logic signed [15:0] sigmoid_q(input logic signed [17:0] x);
      logic [17:0] a;
      logic [17:0] y;
      logic [17:0] r;
      a = x[17] ? 18'(-x) : 18'(x);
      if (a >= SIG_T5) begin
         y = SIG_ONE;
      end else if (a >= SIG_T238) begin
         y = (a >> 5) + SIG_C27;
      end else if (a >= SIG_ONE) begin
         y = (a >> 3) + SIG_C5;
      end else begin
         y = (a >> 2) + SIG_HALF;
      end
      r = x[17] ? (SIG_ONE - y) : y;
      return r[15:0];
   endfunction

   // tanh(x) = 2 * sigmoid(2x) - 1, with 2x kept at full width.
   function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
      logic signed [15:0] s;
      logic signed [16:0] t;
      s = sigmoid_q({x[15], x, 1'b0});
      t = $signed({s, 1'b0}) - 17'(ONE_Q);
      return t[15:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcs_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module lcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lcs_ctrl.sv @@
// Controller state machine that sequences loads, gate sums, updates and results.
`timescale 1ns / 1ps
`default_nettype none

module lcs_ctrl
   import lcs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   input  wire logic  req_tuser,
   input  wire logic  req_tlast,
   output      logic  req_tready,
   output      logic  rsp_tvalid,
   input  wire logic  rsp_tready,
   output lcs_cmd_type cmd
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_MAC   = 11'b000_0000_0010,
      S_DRAIN = 11'b000_0000_0100,
      S_ROUND = 11'b000_0000_1000,
      S_ACT   = 11'b000_0001_0000,
      S_CF    = 11'b000_0010_0000,
      S_CELL  = 11'b000_0100_0000,
      S_TANH  = 11'b000_1000_0000,
      S_HID   = 11'b001_0000_0000,
      S_OUTL  = 11'b010_0000_0000,
      S_EMIT  = 11'b100_0000_0000
   } state_type;

   localparam logic [HW-1:0]     LAST_UNIT = HW'(HIDDEN_SIZE - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HIDDEN_SIZE + 2);
   localparam logic [STEP_W-1:0] RB_STEP   = STEP_W'(HIDDEN_SIZE + 1);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        gate_ff, gate_in;
   logic [HW-1:0]     unit_ff, unit_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic              drain_ff, drain_in;
   logic              eos_ff, eos_in;

   // Next-state and command logic.
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      step_in    = step_ff;
      gate_in    = gate_ff;
      unit_in    = unit_ff;
      raddr_in   = raddr_ff;
      drain_in   = drain_ff;
      eos_in     = eos_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.upd    = UPD_NONE;
      cmd.gate   = gate_ff;
      cmd.unit   = unit_ff;
      cmd.k      = HW'(step_ff - STEP_W'(1));
      cmd.out_last = (unit_ff == LAST_UNIT);

      unique case (state_ff)
         S_IDLE: begin
            // No transaction is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               if (req_tuser == KIND_LOAD) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  eos_in   = req_tlast;
                  row_in   = '0;
                  step_in  = '0;
                  gate_in  = G_I;
                  unit_in  = '0;
                  raddr_in = ADDR_W'(R_BASE);
                  state_in = S_MAC;
               end
            end
         end
         S_MAC: begin
            // One store read per term of the gate sum.
            cmd.rd_en = 1'b1;
            if (step_ff == '0) begin
               cmd.rd_addr = ADDR_W'(row_ff);
               cmd.op      = OP_MUL_X;
               cmd.first   = 1'b1;
            end else if (step_ff == RB_STEP) begin
               cmd.rd_addr = ADDR_W'(B_BASE) + ADDR_W'(row_ff);
               cmd.op      = OP_BIAS;
            end else if (step_ff == LAST_STEP) begin
               cmd.rd_addr = ADDR_W'(RB_BASE) + ADDR_W'(row_ff);
               cmd.op      = OP_BIAS;
            end else begin
               cmd.rd_addr = raddr_ff;
               cmd.op      = OP_MUL_H;
               raddr_in    = raddr_ff + ADDR_W'(1);
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DRAIN: begin
            // Wait for the last term to reach the accumulator.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_ACT;
         end
         S_ACT: begin
            cmd.act_wr = 1'b1;
            row_in     = row_ff + ROW_W'(1);
            if (unit_ff == LAST_UNIT) begin
               unit_in = '0;
               if (gate_ff == G_C) begin
                  state_in = S_CF;
               end else begin
                  gate_in  = gate_ff + 2'd1;
                  state_in = S_MAC;
               end
            end else begin
               unit_in  = unit_ff + HW'(1);
               state_in = S_MAC;
            end
         end
         S_CF: begin
            cmd.upd  = UPD_CF;
            state_in = S_CELL;
         end
         S_CELL: begin
            cmd.upd  = UPD_CELL;
            state_in = S_TANH;
         end
         S_TANH: begin
            cmd.upd  = UPD_TANH;
            state_in = S_HID;
         end
         S_HID: begin
            cmd.upd = UPD_HID;
            if (unit_ff == LAST_UNIT) begin
               unit_in  = '0;
               state_in = eos_ff ? S_OUTL : S_IDLE;
            end else begin
               unit_in  = unit_ff + HW'(1);
               state_in = S_CF;
            end
         end
         S_OUTL: begin
            cmd.upd  = UPD_OUT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (unit_ff == LAST_UNIT) begin
                  cmd.upd  = UPD_CLEAR;
                  state_in = S_IDLE;
               end else begin
                  unit_in  = unit_ff + HW'(1);
                  state_in = S_OUTL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         step_ff  <= '0;
         gate_ff  <= G_I;
         unit_ff  <= '0;
         raddr_ff <= '0;
         drain_ff <= 1'b0;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         step_ff  <= step_in;
         gate_ff  <= gate_in;
         unit_ff  <= unit_in;
         raddr_ff <= raddr_in;
         drain_ff <= drain_in;
         eos_ff   <= eos_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lcs_dp.sv @@
// Datapath: weight store, multiply-accumulate pipeline, activations and state vectors.
`timescale 1ns / 1ps
`default_nettype none

module lcs_dp
   import lcs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  lcs_cmd_type                   cmd,
   input  wire logic [WIDX_W-1:0]        weight_index,
   input  wire logic signed [VAL_W-1:0]  weight_value,
   input  wire logic signed [VAL_W-1:0]  sample,
   output      logic [OIDX_W-1:0]        out_index,
   output      logic signed [VAL_W-1:0]  out_value,
   output      logic                     out_last
);

   logic [VAL_W-1:0]        rd_data;
   logic                    store_wr;
   logic signed [VAL_W-1:0] x_ff;

   // Weight store.
   assign store_wr = cmd.wr_en && (weight_index < WIDX_W'(STORE_DEPTH));

   lcs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (ADDR_W'(weight_index)),
      .wr_data (weight_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   // Sample latch.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= sample;
      end
   end

   // Operation tags that travel with the store read.
   mac_op_type              op_d_ff;
   logic                    first_d_ff, first_dd_ff, term_vld_ff;
   logic [HW-1:0]           k_d_ff;
   logic signed [ACC_W-1:0] term_ff, term_in, acc_ff;
   logic signed [VAL_W-1:0] hid_ff  [HIDDEN_SIZE];
   logic signed [VAL_W-1:0] cell_ff [HIDDEN_SIZE];
   logic signed [VAL_W-1:0] gi_ff   [HIDDEN_SIZE];
   logic signed [VAL_W-1:0] go_ff   [HIDDEN_SIZE];
   logic signed [VAL_W-1:0] gf_ff   [HIDDEN_SIZE];
   logic signed [VAL_W-1:0] gc_ff   [HIDDEN_SIZE];
   logic [HW-1:0]           hidx;
   logic signed [VAL_W-1:0] hid_rd, opnd;
   logic signed [31:0]      prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_d_ff     <= OP_NONE;
         term_vld_ff <= 1'b0;
      end else begin
         op_d_ff     <= cmd.op;
         term_vld_ff <= (op_d_ff != OP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      first_d_ff  <= cmd.first;
      first_dd_ff <= first_d_ff;
      k_d_ff      <= cmd.k;
   end

   // One read index into the hidden vector, shared by the sum and the result path.
   assign hidx   = (op_d_ff == OP_MUL_H) ? k_d_ff : cmd.unit;
   assign hid_rd = hid_ff[hidx];
   assign opnd   = (op_d_ff == OP_MUL_X) ? x_ff : hid_rd;
   assign prod   = $signed(rd_data) * opnd;

   // Product or shifted bias term.
   always_comb begin
      if (op_d_ff == OP_BIAS) begin
         term_in = ACC_W'($signed(rd_data)) <<< FRAC_BITS;
      end else begin
         term_in = ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   // Accumulator.
   always_ff @(posedge clock) begin
      if (term_vld_ff) begin
         acc_ff <= first_dd_ff ? term_ff : (acc_ff + term_ff);
      end
   end

   // Rounding and activation of one gate.
   logic signed [VAL_W-1:0] pre_ff, act_val;

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         pre_ff <= round_sat(acc_ff);
      end
   end

   assign act_val = (cmd.gate == G_C) ? tanh_q(pre_ff)
                                       : sigmoid_q({{2{pre_ff[15]}}, pre_ff});

   always_ff @(posedge clock) begin
      if (cmd.act_wr) begin
         unique case (cmd.gate)
            G_I:     gi_ff[cmd.unit] <= act_val;
            G_O:     go_ff[cmd.unit] <= act_val;
            G_F:     gf_ff[cmd.unit] <= act_val;
            default: gc_ff[cmd.unit] <= act_val;
         endcase
      end
   end

   // Cell and hidden update of one unit.
   logic signed [31:0]      cf_ff, ig_prod, ot_prod;
   logic signed [VAL_W-1:0] t_ff, cell_new, hid_new;

   assign ig_prod  = gi_ff[cmd.unit] * gc_ff[cmd.unit];
   assign ot_prod  = go_ff[cmd.unit] * t_ff;
   assign cell_new = round_sat(ACC_W'(cf_ff) + ACC_W'(ig_prod));
   assign hid_new  = round_sat(ACC_W'(ot_prod));

   always_ff @(posedge clock) begin
      if (cmd.upd == UPD_CF) begin
         cf_ff <= cell_ff[cmd.unit] * gf_ff[cmd.unit];
      end
      if (cmd.upd == UPD_TANH) begin
         t_ff <= tanh_q(cell_ff[cmd.unit]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.upd == UPD_CLEAR) begin
         for (int i = 0; i < HIDDEN_SIZE; i++) begin
            hid_ff[i]  <= '0;
            cell_ff[i] <= '0;
         end
      end else begin
         if (cmd.upd == UPD_CELL) begin
            cell_ff[cmd.unit] <= cell_new;
         end
         if (cmd.upd == UPD_HID) begin
            hid_ff[cmd.unit] <= hid_new;
         end
      end
   end

   // Output register for one result transaction.
   always_ff @(posedge clock) begin
      if (cmd.upd == UPD_OUT) begin
         out_index <= OIDX_W'(cmd.unit);
         out_value <= hid_rd;
         out_last  <= cmd.out_last;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lstm_cell_sequence_unit.sv @@
// Top level of the single-input LSTM layer with an i, o, f, c gate order.
//
//   Port group   Direction   Carries
//   req_*        in          weight load or input sample (tuser = kind, tlast = end of sequence)
//   rsp_*        out         final hidden vector, one unit per transaction (tlast on last unit)
//
// A sample runs through the single multiply-accumulate unit, which reads one store word
// per cycle while it forms a gate sum.
// At end of sequence each result passes S_OUTL, then S_EMIT, which waits on the result side.
// Synchronous active-high reset clears h, c and the controller; the weight store is not cleared.
// The request side is ready only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module lstm_cell_sequence_unit
   import lcs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,  // weight_index[9:0], weight_value[25:10], sample[41:26]
   input  wire logic        req_tuser,  // kind
   input  wire logic        req_tlast,  // end_of_sequence
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,  // hidden_index[3:0], hidden_value[19:4]
   output      logic        rsp_tlast   // last
);

   lcs_cmd_type             cmd;
   logic [OIDX_W-1:0]       out_index;
   logic signed [VAL_W-1:0] out_value;

   lcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lcs_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .weight_index (req_tdata[9:0]),
      .weight_value (req_tdata[25:10]),
      .sample       (req_tdata[41:26]),
      .out_index    (out_index),
      .out_value    (out_value),
      .out_last     (rsp_tlast)
   );

   // Pack the result transaction.
   assign rsp_tdata = {4'b0, out_value, out_index};

endmodule

`default_nettype wire

@@ tb/lstm_cell_sequence_unit_tb.sv @@
// Self-checking testbench of the LSTM cell sequence unit, with a predictor of its own.
`timescale 1ns / 1ps
`default_nettype none

module lstm_cell_sequence_unit_tb;
   import lcs_pkg::*;

   // One request transaction, plus a flag that holds it back until all results are in.
   typedef struct {
      logic        kind;
      logic [9:0]  widx;
      logic [15:0] wval;
      logic [15:0] smp;
      logic        eos;
      bit          drain;
   } lstm_req_type;

   // One expected hidden-unit result.
   typedef struct {
      logic [3:0]  unit;
      logic [15:0] value;
      logic        last;
   } hidden_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // weight_index[9:0], weight_value[25:10], sample[41:26]
   logic        req_tuser = 1'b0; // kind
   logic        req_tlast = 1'b0; // end_of_sequence
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // hidden_index[3:0], hidden_value[19:4]
   logic        rsp_tlast;

   lstm_req_type      pending_reqs[$];
   hidden_result_type hidden_expect[$];
   int                error_count = 0;

   // Predictor state: weight store, hidden and cell vectors.
   int weight_mem[STORE_DEPTH];
   int h_vec[HIDDEN_SIZE];
   int c_vec[HIDDEN_SIZE];

   lstm_cell_sequence_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Round half up to the fixed-point grid and clamp to 16 bits.
   function automatic int fix_round(input longint v);
      longint r;
      r = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
   endfunction

   // Piecewise linear sigmoid on the magnitude, mirrored for negative inputs.
   function automatic int plan_sigmoid(input int x);
      int one;
      int a;
      int y;
      one = 1 << FRAC_BITS;
      a = (x < 0) ? -x : x;
      if (a >= 5 * one) y = one;
      else if (a >= (19 * one) / 8) y = (a >>> 5) + (27 * one) / 32;
      else if (a >= one) y = (a >>> 3) + (5 * one) / 8;
      else y = (a >>> 2) + one / 2;
      return (x < 0) ? one - y : y;
   endfunction

   function automatic int plan_tanh(input int x);
      return 2 * plan_sigmoid(2 * x) - (1 << FRAC_BITS);
   endfunction

   // Apply one accepted request to the predictor and queue any results.
   task automatic predict_lstm(input lstm_req_type r);
      int     gates[4][HIDDEN_SIZE];
      int     row;
      longint acc;
      int     x;
      hidden_result_type res;
      if (r.kind == KIND_LOAD) begin
         if (r.widx < STORE_DEPTH) weight_mem[r.widx] = int'($signed(r.wval));
         return;
      end
      x = int'($signed(r.smp));
      for (int g = 0; g < 4; g++) begin
         for (int u = 0; u < HIDDEN_SIZE; u++) begin
            row = g * HIDDEN_SIZE + u;
            acc = longint'(x) * weight_mem[row];
            for (int k = 0; k < HIDDEN_SIZE; k++)
               acc += longint'(h_vec[k]) * weight_mem[R_BASE + row * HIDDEN_SIZE + k];
            acc += (longint'(weight_mem[B_BASE + row]) +
                    weight_mem[B_BASE + 4 * HIDDEN_SIZE + row]) <<< FRAC_BITS;
            gates[g][u] = (g == 3) ? plan_tanh(fix_round(acc)) : plan_sigmoid(fix_round(acc));
         end
      end
      for (int u = 0; u < HIDDEN_SIZE; u++) begin
         c_vec[u] = fix_round(longint'(c_vec[u]) * gates[2][u] +
                              longint'(gates[0][u]) * gates[3][u]);
         h_vec[u] = fix_round(longint'(gates[1][u]) * plan_tanh(c_vec[u]));
      end
      if (!r.eos) return;
      for (int u = 0; u < HIDDEN_SIZE; u++) begin
         res.unit  = 4'(u);
         res.value = 16'(h_vec[u]);
         res.last  = (u == HIDDEN_SIZE - 1);
         hidden_expect.push_back(res);
         h_vec[u] = 0;
         c_vec[u] = 0;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic lstm_req_type make_load(input int idx, input int val);
      lstm_req_type r;
      r.kind = KIND_LOAD;
      r.widx = 10'(idx);
      r.wval = 16'(val);
      r.smp  = 16'($urandom);
      r.eos  = $urandom_range(0, 1);
      r.drain = 0;
      return r;
   endfunction

   function automatic lstm_req_type make_sample(input int smp, input bit eos);
      lstm_req_type r;
      r.kind = KIND_SAMPLE;
      r.widx = 10'($urandom);
      r.wval = 16'($urandom);
      r.smp  = 16'(smp);
      r.eos  = eos;
      r.drain = 0;
      return r;
   endfunction

   // Moderate weights keep most gates out of saturation.
   function automatic int pick_weight(input int idx);
      if ($urandom_range(0, 19) == 0) return int'($signed(16'($urandom)));
      if (idx < R_BASE) return $urandom_range(0, 12000) - 6000;
      if (idx < B_BASE) return $urandom_range(0, 1600) - 800;
      return $urandom_range(0, 4000) - 2000;
   endfunction

   // Request driver: one transaction at a time from the pending queue.
   int           req_gap = 0;
   int           req_count = 0;
   lstm_req_type cur_req;
   always @(posedge clock) begin
      bit fire;
      bit next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) predict_lstm(cur_req);
         if (!req_tvalid || fire) begin
            next_valid = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && hidden_expect.size() > 0)) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {6'b0, cur_req.smp, cur_req.wval, cur_req.widx};
               req_tuser <= cur_req.kind;
               req_tlast <= cur_req.eos;
               next_valid = 1'b1;
               req_count++;
               // Stretches without gaps alternate with random gaps.
               req_gap = ((req_count / 60) % 2 == 1) ? 0 : $urandom_range(0, 6);
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // One long hold-off on the result side, started once results are due.
   int long_hold = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!long_hold_done && hidden_expect.size() > 0) begin
            long_hold = 2000;
            long_hold_done = 1;
         end else if (long_hold > 0) begin
            long_hold--;
         end
      end
   end

   // Result monitor: compares each transaction with the oldest expectation.
   int rsp_gap = 0;
   int rsp_count = 0;
   always @(posedge clock) begin
      hidden_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (hidden_expect.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = hidden_expect.pop_front();
               if (rsp_tdata[3:0] !== e.unit)
                  report_mismatch($sformatf("unit %0d, expected %0d", rsp_tdata[3:0], e.unit));
               if (rsp_tdata[19:4] !== e.value)
                  report_mismatch($sformatf("unit %0d value %h, expected %h",
                                            e.unit, rsp_tdata[19:4], e.value));
               if (rsp_tdata[23:20] !== 4'b0)
                  report_mismatch("padding bits of the result are not zero");
               if (rsp_tlast !== e.last)
                  report_mismatch($sformatf("unit %0d last %b", e.unit, rsp_tlast));
            end
            rsp_gap = ((rsp_count / 50) % 2 == 1) ? 0 : $urandom_range(0, 6);
         end
         if (long_hold > 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      lstm_req_type r;
      int seq_len;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         weight_mem[i] = 0;
      end
      for (int u = 0; u < HIDDEN_SIZE; u++) begin
         h_vec[u] = 0;
         c_vec[u] = 0;
      end

      // Fill the whole store first, so no entry is ever read unwritten.
      for (int i = 0; i < STORE_DEPTH; i++) pending_reqs.push_back(make_load(i, pick_weight(i)));

      // Directed: field extremes, loads beyond the store, short and long sequences.
      pending_reqs.push_back(make_sample(32767, 1'b1));
      pending_reqs.push_back(make_sample(-32768, 1'b1));
      pending_reqs.push_back(make_sample(0, 1'b1));
      pending_reqs.push_back(make_load(1023, -32768));
      pending_reqs.push_back(make_load(STORE_DEPTH, 32767));
      pending_reqs.push_back(make_load(0, 32767));
      pending_reqs.push_back(make_load(STORE_DEPTH - 1, -32768));
      pending_reqs.push_back(make_load(R_BASE, 32767));
      pending_reqs.push_back(make_sample(4096, 1'b0));
      pending_reqs.push_back(make_sample(-4096, 1'b0));
      pending_reqs.push_back(make_sample(20000, 1'b0));
      pending_reqs.push_back(make_sample(-20000, 1'b1));
      pending_reqs.push_back(make_load(0, pick_weight(0)));
      pending_reqs.push_back(make_load(R_BASE, pick_weight(R_BASE)));
      pending_reqs.push_back(make_load(STORE_DEPTH - 1, pick_weight(STORE_DEPTH - 1)));
      r = make_sample(1000, 1'b1);
      r.drain = 1;
      pending_reqs.push_back(r);

      // Random: mostly sequences of samples, some weight reloads in between.
      while (pending_reqs.size() < STORE_DEPTH + 230) begin
         seq_len = $urandom_range(1, 8);
         for (int s = 0; s < seq_len; s++) begin
            if ($urandom_range(0, 3) == 0) begin
               r = make_load($urandom_range(0, 1023), 0);
               r.wval = 16'(pick_weight(r.widx));
               pending_reqs.push_back(r);
            end
            r = make_sample(($urandom_range(0, 4) == 0) ? int'($signed(16'($urandom)))
                                                        : $urandom_range(0, 16000) - 8000,
                            s == seq_len - 1);
            r.drain = ($urandom_range(0, 15) == 0);
            pending_reqs.push_back(r);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_tvalid || hidden_expect.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #1500000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
